/* sv/im2col_pkg.sv */
// ----------------------------------------------------------------------------
// im2col_pkg
// Shared types and constants of the NHWC im2col descriptor generator.
// ----------------------------------------------------------------------------
package im2col_pkg;

  // Default geometry field width and address width
  localparam int DIM_BITS_DEF  = 12;
  localparam int ADDR_BITS_DEF = 32;

  // Offset fields on the result stream
  localparam int OFFSET_BITS = 32;

  // Configuration port
  localparam int CFG_DATA_BITS  = 32;
  localparam int CFG_ADDR_BITS  = 5;
  localparam int CFG_INDEX_BITS = 3;

  localparam logic [CFG_INDEX_BITS-1:0] REG_SOURCE_SIZE        = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_OUTPUT_SIZE        = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_KERNEL_SIZE        = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STRIDE_YX          = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DILATION_YX        = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PADDING_YX         = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GROUP_COUNT        = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CHANNELS_PER_GROUP = 3'd7;

  // Request kinds decoded by the front end
  typedef enum logic {
    CMD_NEXT    = 1'b0,
    CMD_RESTART = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
  } cmd_t;

  // One copy descriptor
  typedef struct packed {
    logic                   range_error;
    logic                   last;
    logic [OFFSET_BITS-1:0] dst_offset;
    logic                   zero_fill;
    logic [OFFSET_BITS-1:0] src_offset;
  } desc_t;

endpackage

/* sv/im2col_front.sv */
// ----------------------------------------------------------------------------
// im2col_front
// Request intake: decode each word into a command and hold it in a
// two-entry queue until the descriptor engine takes it.
// ----------------------------------------------------------------------------
module im2col_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_restart,
  output logic               cmd_valid,
  input  logic               cmd_ready,
  output im2col_pkg::cmd_t   cmd
);

  im2col_pkg::cmd_t entries [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             push;
  logic             pop;
  im2col_pkg::cmd_t incoming;

  always_comb begin
    incoming.kind = in_restart ? im2col_pkg::CMD_RESTART : im2col_pkg::CMD_NEXT;
  end

  assign in_ready  = (count != 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = entries[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* sv/im2col_back.sv */
// ----------------------------------------------------------------------------
// im2col_back
// Descriptor engine: walk the tap counters and compute source and
// destination offsets through a short multi-cycle sequence.
// ----------------------------------------------------------------------------
module im2col_back #(
  parameter int DIM_BITS  = im2col_pkg::DIM_BITS_DEF,
  parameter int ADDR_BITS = im2col_pkg::ADDR_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_ready,
  input  im2col_pkg::cmd_t      cmd,
  input  logic [2*DIM_BITS-1:0] source_size,
  input  logic [2*DIM_BITS-1:0] output_size,
  input  logic [2*DIM_BITS-1:0] kernel_size,
  input  logic [2*DIM_BITS-1:0] stride_yx,
  input  logic [2*DIM_BITS-1:0] dilation_yx,
  input  logic [2*DIM_BITS-1:0] padding_yx,
  input  logic [DIM_BITS-1:0]   group_count,
  input  logic [DIM_BITS-1:0]   channels_per_group,
  output logic                  out_valid,
  input  logic                  out_ready,
  output im2col_pkg::desc_t     desc
);

  localparam int PROD_W = 2 * DIM_BITS;
  localparam int POS_W  = 2 * DIM_BITS + 2;
  localparam int SRC_W  = 4 * DIM_BITS + 1;
  localparam int SAT_W  = (SRC_W > ADDR_BITS + 1) ? SRC_W : ADDR_BITS + 1;
  localparam int EXT_W  = (SAT_W > im2col_pkg::OFFSET_BITS) ? SAT_W : im2col_pkg::OFFSET_BITS;
  localparam int DST_W  = (ADDR_BITS > im2col_pkg::OFFSET_BITS) ? ADDR_BITS
                                                                : im2col_pkg::OFFSET_BITS;
  localparam logic [SAT_W-1:0] SRC_MAX =
    {{(SAT_W - ADDR_BITS){1'b0}}, {ADDR_BITS{1'b1}}};
  localparam logic [ADDR_BITS+1:0] COL_CAP = {2'b01, {ADDR_BITS{1'b0}}};

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_POS  = 6'b000100,
    ST_PIX  = 6'b001000,
    ST_SRC  = 6'b010000,
    ST_EMIT = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  // Walk state
  logic [DIM_BITS-1:0]  group_index;
  logic [DIM_BITS-1:0]  out_row;
  logic [DIM_BITS-1:0]  out_col;
  logic [DIM_BITS-1:0]  tap_row;
  logic [DIM_BITS-1:0]  tap_col;
  logic [ADDR_BITS:0]   column_offset;

  // Datapath stage registers
  logic [PROD_W-1:0]    prod_oy;
  logic [PROD_W-1:0]    prod_ky;
  logic [PROD_W-1:0]    prod_ox;
  logic [PROD_W-1:0]    prod_kx;
  logic [PROD_W-1:0]    grp_base;
  logic [PROD_W-1:0]    total_ch;
  logic [DIM_BITS-1:0]  sy_low;
  logic [DIM_BITS-1:0]  sx_low;
  logic                 zero;
  logic [PROD_W-1:0]    pix;
  logic [SRC_W-1:0]     src_sum;

  // Field split
  logic [DIM_BITS-1:0]  src_h, src_w, out_h, out_w, ker_h, ker_w;
  logic [DIM_BITS-1:0]  str_y, str_x, dil_y, dil_x, pad_t, pad_l;

  assign src_h = source_size[2*DIM_BITS-1:DIM_BITS];
  assign src_w = source_size[DIM_BITS-1:0];
  assign out_h = output_size[2*DIM_BITS-1:DIM_BITS];
  assign out_w = output_size[DIM_BITS-1:0];
  assign ker_h = kernel_size[2*DIM_BITS-1:DIM_BITS];
  assign ker_w = kernel_size[DIM_BITS-1:0];
  assign str_y = stride_yx[2*DIM_BITS-1:DIM_BITS];
  assign str_x = stride_yx[DIM_BITS-1:0];
  assign dil_y = dilation_yx[2*DIM_BITS-1:DIM_BITS];
  assign dil_x = dilation_yx[DIM_BITS-1:0];
  assign pad_t = padding_yx[2*DIM_BITS-1:DIM_BITS];
  assign pad_l = padding_yx[DIM_BITS-1:0];

  // Position compare
  logic [POS_W-1:0] sum_y, sum_x;
  logic             zero_y, zero_x;

  always_comb begin
    sum_y  = POS_W'(prod_oy) + POS_W'(prod_ky) - POS_W'(pad_t);
    sum_x  = POS_W'(prod_ox) + POS_W'(prod_kx) - POS_W'(pad_l);
    zero_y = sum_y[POS_W-1] || (sum_y >= POS_W'(src_h));
    zero_x = sum_x[POS_W-1] || (sum_x >= POS_W'(src_w));
  end

  // Counter advance; a zero bound counts as one
  logic [DIM_BITS:0]   bnd_g, bnd_oh, bnd_ow, bnd_kh, bnd_kw;
  logic [DIM_BITS:0]   inc_g, inc_oh, inc_ow, inc_kh, inc_kw;
  logic                wrap_g, wrap_oh, wrap_ow, wrap_kh, wrap_kw;
  logic                last_tap;

  always_comb begin
    bnd_g   = (group_count == '0) ? (DIM_BITS+1)'(1) : {1'b0, group_count};
    bnd_oh  = (out_h == '0) ? (DIM_BITS+1)'(1) : {1'b0, out_h};
    bnd_ow  = (out_w == '0) ? (DIM_BITS+1)'(1) : {1'b0, out_w};
    bnd_kh  = (ker_h == '0) ? (DIM_BITS+1)'(1) : {1'b0, ker_h};
    bnd_kw  = (ker_w == '0) ? (DIM_BITS+1)'(1) : {1'b0, ker_w};
    inc_g   = {1'b0, group_index} + (DIM_BITS+1)'(1);
    inc_oh  = {1'b0, out_row} + (DIM_BITS+1)'(1);
    inc_ow  = {1'b0, out_col} + (DIM_BITS+1)'(1);
    inc_kh  = {1'b0, tap_row} + (DIM_BITS+1)'(1);
    inc_kw  = {1'b0, tap_col} + (DIM_BITS+1)'(1);
    wrap_g  = inc_g >= bnd_g;
    wrap_oh = inc_oh >= bnd_oh;
    wrap_ow = inc_ow >= bnd_ow;
    wrap_kh = inc_kh >= bnd_kh;
    wrap_kw = inc_kw >= bnd_kw;
    last_tap = wrap_g && wrap_oh && wrap_ow && wrap_kh && wrap_kw;
  end

  // Offset saturation
  logic [SAT_W-1:0]     src_ext;
  logic                 src_over;
  logic [SAT_W-1:0]     src_sat;
  logic [EXT_W-1:0]     src_wide;
  logic                 dst_over;
  logic [ADDR_BITS-1:0] dst_sat;
  logic [DST_W-1:0]     dst_wide;
  logic [ADDR_BITS+1:0] col_sum;
  logic [ADDR_BITS:0]   col_next;

  always_comb begin
    src_ext  = SAT_W'(src_sum);
    src_over = !zero && (src_ext > SRC_MAX);
    if (zero) begin
      src_sat = '0;
    end else if (src_over) begin
      src_sat = SRC_MAX;
    end else begin
      src_sat = src_ext;
    end
    src_wide = EXT_W'(src_sat);
    dst_over = column_offset[ADDR_BITS];
    dst_sat  = dst_over ? {ADDR_BITS{1'b1}} : column_offset[ADDR_BITS-1:0];
    dst_wide = DST_W'(dst_sat);
    col_sum  = (ADDR_BITS+2)'(column_offset) + (ADDR_BITS+2)'(channels_per_group);
    col_next = (col_sum > COL_CAP) ? COL_CAP[ADDR_BITS:0] : col_sum[ADDR_BITS:0];
  end

  logic take;
  logic emit;

  assign cmd_ready = (state == ST_IDLE);
  assign take      = cmd_valid && cmd_ready;
  assign emit      = (state == ST_EMIT) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (take) state_next = ST_MUL;
      ST_MUL:  state_next = ST_POS;
      ST_POS:  state_next = ST_PIX;
      ST_PIX:  state_next = ST_SRC;
      ST_SRC:  state_next = ST_EMIT;
      ST_EMIT: if (emit) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      group_index   <= '0;
      out_row       <= '0;
      out_col       <= '0;
      tap_row       <= '0;
      tap_col       <= '0;
      column_offset <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (take && cmd.kind == im2col_pkg::CMD_RESTART) begin
        group_index   <= '0;
        out_row       <= '0;
        out_col       <= '0;
        tap_row       <= '0;
        tap_col       <= '0;
        column_offset <= '0;
      end
      if (emit) begin
        out_valid <= 1'b1;
        // Wrap everything after the final tap, else step the innermost counter
        if (last_tap) begin
          column_offset <= '0;
        end else begin
          column_offset <= col_next;
        end
        tap_col <= wrap_kw ? '0 : inc_kw[DIM_BITS-1:0];
        if (wrap_kw) begin
          tap_row <= wrap_kh ? '0 : inc_kh[DIM_BITS-1:0];
          if (wrap_kh) begin
            out_col <= wrap_ow ? '0 : inc_ow[DIM_BITS-1:0];
            if (wrap_ow) begin
              out_row <= wrap_oh ? '0 : inc_oh[DIM_BITS-1:0];
              if (wrap_oh) begin
                group_index <= wrap_g ? '0 : inc_g[DIM_BITS-1:0];
              end
            end
          end
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath: one step per state: products, position check, pixel index, source offset
  always_ff @(posedge clk) begin
    case (state)
      ST_MUL: begin
        prod_oy  <= PROD_W'(out_row) * PROD_W'(str_y);
        prod_ky  <= PROD_W'(tap_row) * PROD_W'(dil_y);
        prod_ox  <= PROD_W'(out_col) * PROD_W'(str_x);
        prod_kx  <= PROD_W'(tap_col) * PROD_W'(dil_x);
        grp_base <= PROD_W'(group_index) * PROD_W'(channels_per_group);
        total_ch <= PROD_W'(group_count) * PROD_W'(channels_per_group);
      end
      ST_POS: begin
        sy_low <= sum_y[DIM_BITS-1:0];
        sx_low <= sum_x[DIM_BITS-1:0];
        zero   <= zero_y || zero_x;
      end
      ST_PIX: begin
        pix <= PROD_W'(sy_low) * PROD_W'(src_w) + PROD_W'(sx_low);
      end
      ST_SRC: begin
        src_sum <= SRC_W'(pix) * SRC_W'(total_ch) + SRC_W'(grp_base);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      desc.src_offset  <= src_wide[im2col_pkg::OFFSET_BITS-1:0];
      desc.zero_fill   <= zero;
      desc.dst_offset  <= dst_wide[im2col_pkg::OFFSET_BITS-1:0];
      desc.last        <= last_tap;
      desc.range_error <= src_over || dst_over;
    end
  end

endmodule

/* sv/im2col_address_generator_top.sv */
// ----------------------------------------------------------------------------
// im2col_address_generator_top
// NHWC im2col copy descriptor generator with an APB register bank.
// ----------------------------------------------------------------------------
//
//   Channel   Dir  Handshake                  Contents
//   s_axis    in   s_axis_tvalid/tready       tdata[0] restart
//   m_axis    out  m_axis_tvalid/tready       tdata src/dst offsets, tuser flags,
//                                             tlast final descriptor of the unfold
//   apb       in   psel/penable, pready = 1   geometry, stride, dilation, padding,
//                                             group count, channels per group
//
// Each request steps through the engine states in order: taken from the queue
// in idle, then products, position check, pixel index and source offset, then
// emit; the engine works on one request at a time since every descriptor
// updates the walk counters. Synchronous reset clears the walk, the queue and
// the output, and loads the register defaults. The two-entry request queue
// keeps taking words while the engine waits, until it is full; the engine holds
// a finished descriptor in its output register until the sink takes it.
//
module im2col_address_generator_top #(
  parameter int DIM_BITS  = im2col_pkg::DIM_BITS_DEF,
  parameter int ADDR_BITS = im2col_pkg::ADDR_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // Requests
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [7:0]                            s_axis_tdata,  // [0] restart
  // Descriptors
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [2*im2col_pkg::OFFSET_BITS-1:0]  m_axis_tdata,  // [31:0] src_offset,
                                                               // [63:32] dst_offset
  output logic [1:0]                            m_axis_tuser,  // [0] zero_fill,
                                                               // [1] range_error
  output logic                                  m_axis_tlast,
  // Configuration
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [im2col_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  logic [im2col_pkg::CFG_DATA_BITS-1:0]  pwdata,
  output logic [im2col_pkg::CFG_DATA_BITS-1:0]  prdata,
  output logic                                  pready
);

  localparam int PAIR_W = 2 * DIM_BITS;
  localparam logic [PAIR_W-1:0] PAIR_ONES = {{(DIM_BITS-1){1'b0}}, 1'b1,
                                             {(DIM_BITS-1){1'b0}}, 1'b1};

  // Register bank
  logic [PAIR_W-1:0]   source_size;
  logic [PAIR_W-1:0]   output_size;
  logic [PAIR_W-1:0]   kernel_size;
  logic [PAIR_W-1:0]   stride_yx;
  logic [PAIR_W-1:0]   dilation_yx;
  logic [PAIR_W-1:0]   padding_yx;
  logic [DIM_BITS-1:0] group_count;
  logic [DIM_BITS-1:0] channels_per_group;

  logic                                  cfg_write;
  logic [im2col_pkg::CFG_INDEX_BITS-1:0] cfg_index;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_index = paddr[im2col_pkg::CFG_ADDR_BITS-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      source_size        <= PAIR_ONES;
      output_size        <= PAIR_ONES;
      kernel_size        <= PAIR_ONES;
      stride_yx          <= PAIR_ONES;
      dilation_yx        <= PAIR_ONES;
      padding_yx         <= '0;
      group_count        <= DIM_BITS'(1);
      channels_per_group <= DIM_BITS'(1);
    end else if (cfg_write) begin
      // Keep the field bits of each register, drop the rest of the word
      case (cfg_index)
        im2col_pkg::REG_SOURCE_SIZE:        source_size        <= pwdata[PAIR_W-1:0];
        im2col_pkg::REG_OUTPUT_SIZE:        output_size        <= pwdata[PAIR_W-1:0];
        im2col_pkg::REG_KERNEL_SIZE:        kernel_size        <= pwdata[PAIR_W-1:0];
        im2col_pkg::REG_STRIDE_YX:          stride_yx          <= pwdata[PAIR_W-1:0];
        im2col_pkg::REG_DILATION_YX:        dilation_yx        <= pwdata[PAIR_W-1:0];
        im2col_pkg::REG_PADDING_YX:         padding_yx         <= pwdata[PAIR_W-1:0];
        im2col_pkg::REG_GROUP_COUNT:        group_count        <= pwdata[DIM_BITS-1:0];
        im2col_pkg::REG_CHANNELS_PER_GROUP: channels_per_group <= pwdata[DIM_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Read back
  always_comb begin
    case (cfg_index)
      im2col_pkg::REG_SOURCE_SIZE:  prdata = im2col_pkg::CFG_DATA_BITS'(source_size);
      im2col_pkg::REG_OUTPUT_SIZE:  prdata = im2col_pkg::CFG_DATA_BITS'(output_size);
      im2col_pkg::REG_KERNEL_SIZE:  prdata = im2col_pkg::CFG_DATA_BITS'(kernel_size);
      im2col_pkg::REG_STRIDE_YX:    prdata = im2col_pkg::CFG_DATA_BITS'(stride_yx);
      im2col_pkg::REG_DILATION_YX:  prdata = im2col_pkg::CFG_DATA_BITS'(dilation_yx);
      im2col_pkg::REG_PADDING_YX:   prdata = im2col_pkg::CFG_DATA_BITS'(padding_yx);
      im2col_pkg::REG_GROUP_COUNT:  prdata = im2col_pkg::CFG_DATA_BITS'(group_count);
      im2col_pkg::REG_CHANNELS_PER_GROUP:
        prdata = im2col_pkg::CFG_DATA_BITS'(channels_per_group);
      default:                      prdata = '0;
    endcase
  end

  // Front end: decode and queue requests
  logic             cmd_valid;
  logic             cmd_ready;
  im2col_pkg::cmd_t cmd;

  im2col_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_restart (s_axis_tdata[0]),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd)
  );

  // Back end: walk taps and produce descriptors
  im2col_pkg::desc_t desc;

  im2col_back #(
    .DIM_BITS  (DIM_BITS),
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk                (clk),
    .rst                (rst),
    .cmd_valid          (cmd_valid),
    .cmd_ready          (cmd_ready),
    .cmd                (cmd),
    .source_size        (source_size),
    .output_size        (output_size),
    .kernel_size        (kernel_size),
    .stride_yx          (stride_yx),
    .dilation_yx        (dilation_yx),
    .padding_yx         (padding_yx),
    .group_count        (group_count),
    .channels_per_group (channels_per_group),
    .out_valid          (m_axis_tvalid),
    .out_ready          (m_axis_tready),
    .desc               (desc)
  );

  // Pack the descriptor word
  assign m_axis_tdata = {desc.dst_offset, desc.src_offset};
  assign m_axis_tuser = {desc.range_error, desc.zero_fill};
  assign m_axis_tlast = desc.last;

endmodule
